[sv/chull_pkg.sv]
// Shared types and constants of the convex hull area block.
// Used by the multiply-accumulate unit and the top level; depends on nothing.
package chull_pkg;

    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + 6;
    localparam int AREA_W  = 42;
    localparam int HULL_W  = 11;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_point;

    typedef struct packed {
        logic [AREA_W-1:0] doubled_area;
        logic [HULL_W-1:0] hull_points;
        logic              too_few;
        logic              overflow;
    } t_result;

    typedef enum logic [2:0] {
        MAC_NOP  = 3'd0,
        MAC_CLR  = 3'd1,
        MAC_LOAD = 3'd2,
        MAC_ADD  = 3'd3,
        MAC_SUB  = 3'd4
    } t_mac_op;

    typedef struct packed {
        t_mac_op op;
        t_diff   a;
        t_diff   b;
    } t_mac_cmd;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_mac_stat;

endpackage

[sv/chull_stream_if.sv]
// Valid/ready stream interface that carries one payload item per handshake.
// The payload type is a parameter; no package is needed here.
interface chull_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/chull_mac.sv]
// Shared signed multiply-accumulate unit: one registered multiplier and one accumulator.
// Depends on chull_pkg for the operand, accumulator and command types.
module chull_mac
    import chull_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mac_cmd  i_cmd,
    output t_acc      o_acc,
    output t_mac_stat o_stat
);

    t_mac_op                   r_op;
    logic signed [PROD_W-1:0]  r_prod;
    t_acc                      r_acc;
    t_acc                      n_acc;
    t_acc                      w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= MAC_NOP;
            r_acc <= '0;
        end else begin
            r_op  <= i_cmd.op;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_cmd.a) * $signed(i_cmd.b);
    end

    assign w_prod_ext = t_acc'(r_prod);

    always_comb begin
        case (r_op)
            MAC_CLR:  n_acc = '0;
            MAC_LOAD: n_acc = w_prod_ext;
            MAC_ADD:  n_acc = r_acc + w_prod_ext;
            MAC_SUB:  n_acc = r_acc - w_prod_ext;
            default:  n_acc = r_acc;
        endcase
    end

    assign o_acc      = r_acc;
    assign o_stat.neg = r_acc[ACC_W-1];
    assign o_stat.pos = !r_acc[ACC_W-1] && (r_acc != '0);

`ifndef ASSERT_OFF
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == MAC_CLR) |=> ##1 (r_acc == '0))
        else $error("accumulator not zero two cycles after a clear");
    a_load_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == MAC_LOAD) |=> (r_acc == $past(w_prod_ext)))
        else $error("accumulator load did not take the registered product");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == MAC_NOP) |=> $stable(r_acc))
        else $error("accumulator changed without a command");
`endif

endmodule

[sv/convex_hull_area.sv]
// Convex hull area top level: point store, angle sort, Graham scan and shoelace sum.
// Depends on chull_pkg, chull_stream_if and chull_mac.

// Points enter one item per cycle while the block is loading; the pivot (lowest y,
// then lowest x, first seen on a tie) is tracked as they arrive. The item that
// carries last_point ends the set, and the block then stops taking items until the
// result is formed. Sets of n points are sorted by insertion around the pivot:
// each comparison takes two memory reads and a cross product on the
// single shared multiplier, plus a comparison of squared lengths when the two
// points are collinear with the pivot, and the sort makes at most
// (n-1)*(n-2)/2 comparisons depending on the input order. The scan makes one
// cross product per turn test and the area pass one per hull edge.
// Everything after loading is therefore set by the one multiplier and the single
// read port of each memory, and the sort dominates for large sets. A finished
// result waits in an output register, so loading of the next set goes on while
// it is not yet taken. Sets of fewer than three points report too_few with zero
// area and zero hull points; points beyond MAX_POINTS are dropped and flagged.
module convex_hull_area
    import chull_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    chull_stream_if.sink   i_pt,
    chull_stream_if.source o_res
);

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    // Micro-steps of one comparison on the shared unit.
    localparam logic [3:0] STP_CROSS_LO   = 4'd0;
    localparam logic [3:0] STP_CROSS_HI   = 4'd1;
    localparam logic [3:0] STP_CROSS_TEST = 4'd3;
    localparam logic [3:0] STP_LEN_AX     = 4'd4;
    localparam logic [3:0] STP_LEN_AY     = 4'd5;
    localparam logic [3:0] STP_LEN_BX     = 4'd6;
    localparam logic [3:0] STP_LEN_BY     = 4'd7;
    localparam logic [3:0] STP_LEN_TEST   = 4'd9;

    typedef enum logic [25:0] {
        S_LOAD      = 26'd1 << 0,
        S_SORT_INIT = 26'd1 << 1,
        S_SORT_RDI  = 26'd1 << 2,
        S_SORT_GETI = 26'd1 << 3,
        S_SORT_CHK  = 26'd1 << 4,
        S_SORT_RDB  = 26'd1 << 5,
        S_SORT_GETB = 26'd1 << 6,
        S_SORT_CMP  = 26'd1 << 7,
        S_SORT_INS  = 26'd1 << 8,
        S_SCAN_RDK  = 26'd1 << 9,
        S_SCAN_GETK = 26'd1 << 10,
        S_SCAN_GETC = 26'd1 << 11,
        S_SCAN_CHK  = 26'd1 << 12,
        S_SCAN_T1   = 26'd1 << 13,
        S_SCAN_T2   = 26'd1 << 14,
        S_SCAN_B1   = 26'd1 << 15,
        S_SCAN_B2   = 26'd1 << 16,
        S_SCAN_CMP  = 26'd1 << 17,
        S_SCAN_PUSH = 26'd1 << 18,
        S_AREA_CHK  = 26'd1 << 19,
        S_AREA_A1   = 26'd1 << 20,
        S_AREA_A2   = 26'd1 << 21,
        S_AREA_B1   = 26'd1 << 22,
        S_AREA_B2   = 26'd1 << 23,
        S_AREA_OP   = 26'd1 << 24,
        S_DONE      = 26'd1 << 25
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_drop, n_drop;
    logic              r_few, n_few;
    logic [CNTW-1:0]   r_i, n_i;
    logic [CNTW-1:0]   r_m, n_m;
    logic [CNTW-1:0]   r_k, n_k;
    logic [CNTW-1:0]   r_sp, n_sp;
    logic [3:0]        r_step, n_step;
    logic              r_out_valid;

    // Payload registers.
    t_coord            r_pv_x, n_pv_x;
    t_coord            r_pv_y, n_pv_y;
    logic [IW-1:0]     r_pv_idx, n_pv_idx;
    logic [IW-1:0]     r_cur_idx, n_cur_idx;
    logic [IW-1:0]     r_b_idx, n_b_idx;
    t_diff             r_ax, n_ax;
    t_diff             r_ay, n_ay;
    t_diff             r_bx, n_bx;
    t_diff             r_by, n_by;
    t_coord            r_cx, n_cx;
    t_coord            r_cy, n_cy;
    t_coord            r_tx, n_tx;
    t_coord            r_ty, n_ty;
    t_result           r_out, n_out;

    // Memories and their registered read data.
    logic [2*COORD_W-1:0] r_pt_mem [MAX_POINTS];
    logic [IW-1:0]        r_ord_mem [MAX_POINTS];
    logic [IW-1:0]        r_stk_mem [MAX_POINTS];
    logic [2*COORD_W-1:0] r_pt_q;
    logic [IW-1:0]        r_ord_q;
    logic [IW-1:0]        r_stk_q;

    logic                 w_pt_we;
    logic [IW-1:0]        w_pt_raddr;
    logic                 w_ord_we;
    logic [IW-1:0]        w_ord_waddr, w_ord_wdata, w_ord_raddr;
    logic                 w_stk_we;
    logic [IW-1:0]        w_stk_waddr, w_stk_wdata, w_stk_raddr;

    t_coord               w_in_x, w_in_y, w_rd_x, w_rd_y;
    logic                 w_has_room, w_i_last, w_scan_end, w_out_load;
    logic [CNTW-1:0]      w_km1, w_kp1, w_spm1, w_spm2, w_ip1;
    t_mac_cmd             w_cmd;
    t_acc                 w_acc, w_abs;
    t_mac_stat            w_stat;

    function automatic t_diff f_sub(t_coord a, t_coord b);
        f_sub = t_diff'(a) - t_diff'(b);
    endfunction

    chull_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_acc   (w_acc),
        .o_stat  (w_stat)
    );

    assign w_in_x     = i_pt.data.point_x;
    assign w_in_y     = i_pt.data.point_y;
    assign w_rd_x     = t_coord'(r_pt_q[2*COORD_W-1:COORD_W]);
    assign w_rd_y     = t_coord'(r_pt_q[COORD_W-1:0]);
    assign w_has_room = r_cnt < CNTW'(MAX_POINTS);
    assign w_ip1      = r_i + CNTW'(1);
    assign w_km1      = r_k - CNTW'(1);
    assign w_kp1      = r_k + CNTW'(1);
    assign w_spm1     = r_sp - CNTW'(1);
    assign w_spm2     = r_sp - CNTW'(2);
    assign w_i_last   = (w_ip1 == r_cnt);
    assign w_scan_end = (w_kp1 == r_m);
    assign w_abs      = w_acc[ACC_W-1] ? -w_acc : w_acc;

    assign i_pt.ready  = (r_state == S_LOAD);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Commands to the shared unit. A cross product takes a load (an add in the area pass)
    // and a subtract; the length test loads |a|^2 and subtracts |b|^2 term by term.
    always_comb begin
        w_cmd.op = MAC_NOP;
        w_cmd.a  = r_ax;
        w_cmd.b  = r_by;
        if (r_state == S_SORT_CMP || r_state == S_SCAN_CMP || r_state == S_AREA_OP) begin
            case (r_step)
                STP_CROSS_LO: begin
                    w_cmd.op = (r_state == S_AREA_OP) ? MAC_ADD : MAC_LOAD;
                end
                STP_CROSS_HI: begin
                    w_cmd.op = MAC_SUB;
                    w_cmd.a  = r_bx;
                    w_cmd.b  = r_ay;
                end
                STP_LEN_AX: begin
                    w_cmd.op = MAC_LOAD;
                    w_cmd.a  = r_ax;
                    w_cmd.b  = r_ax;
                end
                STP_LEN_AY: begin
                    w_cmd.op = MAC_ADD;
                    w_cmd.a  = r_ay;
                    w_cmd.b  = r_ay;
                end
                STP_LEN_BX: begin
                    w_cmd.op = MAC_SUB;
                    w_cmd.a  = r_bx;
                    w_cmd.b  = r_bx;
                end
                STP_LEN_BY: begin
                    w_cmd.op = MAC_SUB;
                    w_cmd.a  = r_by;
                    w_cmd.b  = r_by;
                end
                default: begin
                    w_cmd.op = MAC_NOP;
                end
            endcase
        end else if (r_state == S_SCAN_PUSH && w_scan_end) begin
            w_cmd.op = MAC_CLR;
        end
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_few     = r_few;
        n_i       = r_i;
        n_m       = r_m;
        n_k       = r_k;
        n_sp      = r_sp;
        n_step    = r_step + 4'd1;
        n_pv_x    = r_pv_x;
        n_pv_y    = r_pv_y;
        n_pv_idx  = r_pv_idx;
        n_cur_idx = r_cur_idx;
        n_b_idx   = r_b_idx;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_bx      = r_bx;
        n_by      = r_by;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_out     = r_out;
        w_out_load  = 1'b0;
        w_pt_we     = 1'b0;
        w_pt_raddr  = '0;
        w_ord_we    = 1'b0;
        w_ord_waddr = '0;
        w_ord_wdata = '0;
        w_ord_raddr = '0;
        w_stk_we    = 1'b0;
        w_stk_waddr = '0;
        w_stk_wdata = '0;
        w_stk_raddr = '0;

        case (r_state)
            S_LOAD: begin
                if (i_pt.valid) begin
                    if (w_has_room) begin
                        w_pt_we = 1'b1;
                        n_cnt   = r_cnt + CNTW'(1);
                        if (r_cnt == '0 || w_in_y < r_pv_y ||
                            (w_in_y == r_pv_y && w_in_x < r_pv_x)) begin
                            n_pv_x   = w_in_x;
                            n_pv_y   = w_in_y;
                            n_pv_idx = r_cnt[IW-1:0];
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_pt.data.last_point) begin
                        n_few   = (n_cnt < CNTW'(3));
                        n_state = n_few ? S_DONE : S_SORT_INIT;
                    end
                end
            end
            S_SORT_INIT: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = '0;
                w_ord_wdata = r_pv_idx;
                n_m         = CNTW'(1);
                n_i         = '0;
                n_state     = S_SORT_RDI;
            end
            S_SORT_RDI: begin
                w_pt_raddr = r_i[IW-1:0];
                n_state    = S_SORT_GETI;
            end
            S_SORT_GETI: begin
                if (w_rd_x == r_pv_x && w_rd_y == r_pv_y) begin
                    // Copies of the pivot, the pivot itself included, are left out.
                    n_i = w_ip1;
                    if (w_i_last) begin
                        n_k     = '0;
                        n_sp    = '0;
                        n_state = S_SCAN_RDK;
                    end else begin
                        n_state = S_SORT_RDI;
                    end
                end else begin
                    n_ax    = f_sub(w_rd_x, r_pv_x);
                    n_ay    = f_sub(w_rd_y, r_pv_y);
                    n_k     = r_m;
                    n_state = S_SORT_CHK;
                end
            end
            S_SORT_CHK: begin
                if (r_k > CNTW'(1)) begin
                    w_ord_raddr = w_km1[IW-1:0];
                    n_state     = S_SORT_RDB;
                end else begin
                    n_state = S_SORT_INS;
                end
            end
            S_SORT_RDB: begin
                n_b_idx    = r_ord_q;
                w_pt_raddr = r_ord_q;
                n_state    = S_SORT_GETB;
            end
            S_SORT_GETB: begin
                n_bx    = f_sub(w_rd_x, r_pv_x);
                n_by    = f_sub(w_rd_y, r_pv_y);
                n_step  = STP_CROSS_LO;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if ((r_step == STP_CROSS_TEST && w_stat.pos) ||
                    (r_step == STP_LEN_TEST && w_stat.pos)) begin
                    // The new point goes before this one: shift it up a slot.
                    w_ord_we    = 1'b1;
                    w_ord_waddr = r_k[IW-1:0];
                    w_ord_wdata = r_b_idx;
                    n_k         = w_km1;
                    n_state     = S_SORT_CHK;
                end else if ((r_step == STP_CROSS_TEST && w_stat.neg) ||
                             r_step == STP_LEN_TEST) begin
                    n_state = S_SORT_INS;
                end
            end
            S_SORT_INS: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = r_k[IW-1:0];
                w_ord_wdata = r_i[IW-1:0];
                n_m         = r_m + CNTW'(1);
                n_i         = w_ip1;
                if (w_i_last) begin
                    n_k     = '0;
                    n_sp    = '0;
                    n_state = S_SCAN_RDK;
                end else begin
                    n_state = S_SORT_RDI;
                end
            end
            S_SCAN_RDK: begin
                w_ord_raddr = r_k[IW-1:0];
                n_state     = S_SCAN_GETK;
            end
            S_SCAN_GETK: begin
                n_cur_idx  = r_ord_q;
                w_pt_raddr = r_ord_q;
                n_state    = S_SCAN_GETC;
            end
            S_SCAN_GETC: begin
                n_cx    = w_rd_x;
                n_cy    = w_rd_y;
                n_state = (r_k < CNTW'(3)) ? S_SCAN_PUSH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // The stack is never popped below two entries.
                if (r_sp > CNTW'(2)) begin
                    w_stk_raddr = w_spm1[IW-1:0];
                    n_state     = S_SCAN_T1;
                end else begin
                    n_state = S_SCAN_PUSH;
                end
            end
            S_SCAN_T1: begin
                w_pt_raddr = r_stk_q;
                n_state    = S_SCAN_T2;
            end
            S_SCAN_T2: begin
                n_tx        = w_rd_x;
                n_ty        = w_rd_y;
                w_stk_raddr = w_spm2[IW-1:0];
                n_state     = S_SCAN_B1;
            end
            S_SCAN_B1: begin
                w_pt_raddr = r_stk_q;
                n_state    = S_SCAN_B2;
            end
            S_SCAN_B2: begin
                n_ax    = f_sub(r_tx, w_rd_x);
                n_ay    = f_sub(r_ty, w_rd_y);
                n_bx    = f_sub(r_cx, w_rd_x);
                n_by    = f_sub(r_cy, w_rd_y);
                n_step  = STP_CROSS_LO;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_step == STP_CROSS_TEST) begin
                    if (w_stat.neg) begin
                        n_sp    = w_spm1;
                        n_state = S_SCAN_CHK;
                    end else begin
                        n_state = S_SCAN_PUSH;
                    end
                end
            end
            S_SCAN_PUSH: begin
                w_stk_we    = 1'b1;
                w_stk_waddr = r_sp[IW-1:0];
                w_stk_wdata = r_cur_idx;
                n_sp        = r_sp + CNTW'(1);
                if (w_scan_end) begin
                    n_k     = CNTW'(1);
                    n_state = S_AREA_CHK;
                end else begin
                    n_k     = w_kp1;
                    n_state = S_SCAN_RDK;
                end
            end
            S_AREA_CHK: begin
                if (w_kp1 < r_sp) begin
                    w_stk_raddr = r_k[IW-1:0];
                    n_state     = S_AREA_A1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_AREA_A1: begin
                w_pt_raddr = r_stk_q;
                n_state    = S_AREA_A2;
            end
            S_AREA_A2: begin
                n_ax        = f_sub(w_rd_x, r_pv_x);
                n_ay        = f_sub(w_rd_y, r_pv_y);
                w_stk_raddr = w_kp1[IW-1:0];
                n_state     = S_AREA_B1;
            end
            S_AREA_B1: begin
                w_pt_raddr = r_stk_q;
                n_state    = S_AREA_B2;
            end
            S_AREA_B2: begin
                n_bx    = f_sub(w_rd_x, r_pv_x);
                n_by    = f_sub(w_rd_y, r_pv_y);
                n_step  = STP_CROSS_LO;
                n_state = S_AREA_OP;
            end
            S_AREA_OP: begin
                if (r_step == STP_CROSS_HI) begin
                    n_k     = w_kp1;
                    n_state = S_AREA_CHK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_out_load         = 1'b1;
                    n_out.doubled_area = r_few ? '0 : w_abs[AREA_W-1:0];
                    n_out.hull_points  = r_few ? '0 : HULL_W'(r_sp);
                    n_out.too_few      = r_few;
                    n_out.overflow     = r_drop;
                    n_cnt              = '0;
                    n_drop             = 1'b0;
                    n_state            = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_few       <= 1'b0;
            r_i         <= '0;
            r_m         <= '0;
            r_k         <= '0;
            r_sp        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_few   <= n_few;
            r_i     <= n_i;
            r_m     <= n_m;
            r_k     <= n_k;
            r_sp    <= n_sp;
            r_step  <= n_step;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv_x    <= n_pv_x;
        r_pv_y    <= n_pv_y;
        r_pv_idx  <= n_pv_idx;
        r_cur_idx <= n_cur_idx;
        r_b_idx   <= n_b_idx;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_bx      <= n_bx;
        r_by      <= n_by;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_out     <= n_out;
    end

    // Point store: written while loading, one read port.
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[r_cnt[IW-1:0]] <= {w_in_x, w_in_y};
        end
        r_pt_q <= r_pt_mem[w_pt_raddr];
    end

    // Sorted order of point indices.
    always_ff @(posedge i_clk) begin
        if (w_ord_we) begin
            r_ord_mem[w_ord_waddr] <= w_ord_wdata;
        end
        r_ord_q <= r_ord_mem[w_ord_raddr];
    end

    // Hull stack of point indices.
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_q <= r_stk_mem[w_stk_raddr];
    end

`ifndef ASSERT_OFF
    a_sorted_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_DONE && r_state != S_SORT_INIT) |->
        (r_m <= r_cnt))
        else $error("sorted list longer than the stored set");
    a_stack_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP && r_step == STP_CROSS_TEST && w_stat.neg) |->
        (r_sp > CNTW'(2)))
        else $error("scan would pop the stack below two entries");
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the finishing state");
`endif

endmodule

[bench/tb_convex_hull_area.sv]
// Self-checking bench for the convex hull area block: point sets in, hull results out.
// Depends on chull_pkg, chull_stream_if and convex_hull_area.
module tb_convex_hull_area;
    import chull_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP = 1024;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    chull_stream_if #(.t_payload(t_point))  pt_ch ();
    chull_stream_if #(.t_payload(t_result)) res_ch ();

    convex_hull_area #(.MAX_POINTS(MAXP)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        bit      chk;
        t_result val;
    } t_typed;

    // Predictor state: the points of the set being loaded.
    longint set_x[$];
    longint set_y[$];
    bit     set_dropped = 1'b0;
    t_result hull_expect_q[$];
    t_typed  typed_q[$];

    // Typed-in answer for the set that the directed rows are sending.
    bit      typed_chk = 1'b0;
    t_result typed_val = '0;

    int mismatches = 0;
    int idle_cycles = 0;
    bit quiet_mode = 1'b0;   // no idling on either side
    bit long_hold = 1'b0;    // receiver holds off for a long stretch

    // True if point a sorts before point b around the pivot.
    function automatic bit sorts_ahead(int a, int b, int p);
        longint ax, ay, bx, by, lhs, rhs;
        ax = set_x[a] - set_x[p]; ay = set_y[a] - set_y[p];
        bx = set_x[b] - set_x[p]; by = set_y[b] - set_y[p];
        lhs = ax * by; rhs = bx * ay;
        if (lhs != rhs) return lhs > rhs;
        return (ax * ax + ay * ay) > (bx * bx + by * by);
    endfunction

    // Takes one accepted point and queues a hull result when it ends a set.
    task automatic hull_predict(t_point pt);
        int order[$];
        int stk[$];
        int piv, k, cur;
        longint acc, ax, ay, bx, by;
        t_result r;
        t_typed  t;
        if (set_x.size() < MAXP) begin
            set_x.insert(set_x.size(), longint'(pt.point_x));
            set_y.insert(set_y.size(), longint'(pt.point_y));
        end else begin
            set_dropped = 1'b1;
        end
        if (!pt.last_point) return;
        r = '0;
        r.overflow = set_dropped;
        if (set_x.size() < 3) begin
            r.too_few = 1'b1;
        end else begin
            piv = 0;
            for (int i = 1; i < set_x.size(); i++)
                if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
                    piv = i;
            order.insert(0, piv);
            for (int i = 0; i < set_x.size(); i++) begin
                if (set_x[i] == set_x[piv] && set_y[i] == set_y[piv]) continue;
                k = order.size();
                while (k > 1 && sorts_ahead(i, order[k-1], piv)) k--;
                order.insert(k, i);
            end
            for (int j = 0; j < order.size(); j++) begin
                cur = order[j];
                // A strict right turn pops, but never below two entries.
                if (j >= 3) begin
                    while (stk.size() > 2) begin
                        ax = set_x[stk[$]] - set_x[stk[$-1]];
                        ay = set_y[stk[$]] - set_y[stk[$-1]];
                        bx = set_x[cur] - set_x[stk[$-1]];
                        by = set_y[cur] - set_y[stk[$-1]];
                        if (ax * by < bx * ay) void'(stk.pop_back());
                        else break;
                    end
                end
                stk.insert(stk.size(), cur);
            end
            acc = 0;
            for (int j = 1; j + 1 < stk.size(); j++) begin
                ax = set_x[stk[j]] - set_x[piv]; ay = set_y[stk[j]] - set_y[piv];
                bx = set_x[stk[j+1]] - set_x[piv]; by = set_y[stk[j+1]] - set_y[piv];
                acc += ax * by - bx * ay;
            end
            if (acc < 0) acc = -acc;
            r.doubled_area = acc[AREA_W-1:0];
            r.hull_points = HULL_W'(stk.size());
        end
        hull_expect_q.insert(hull_expect_q.size(), r);
        t.chk = typed_chk;
        t.val = typed_val;
        typed_q.insert(typed_q.size(), t);
        set_x.delete();
        set_y.delete();
        set_dropped = 1'b0;
    endtask

    // Monitor: predicts on accepted points, checks accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt_ch.valid && pt_ch.ready) hull_predict(pt_ch.data);
            if (res_ch.valid && res_ch.ready) begin
                if (hull_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
                end else begin
                    if (res_ch.data !== hull_expect_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p",
                                     hull_expect_q[0], res_ch.data);
                    end else if (typed_q[0].chk && res_ch.data !== typed_q[0].val) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("directed mismatch: expected %p, got %p",
                                     typed_q[0].val, res_ch.data);
                    end
                    void'(hull_expect_q.pop_front());
                    void'(typed_q.pop_front());
                end
            end
        end
    end

    // Watchdog: counts cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int n;
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Sends one point and waits until it is accepted.
    task automatic send_point(longint x, longint y, bit last);
        t_point p;
        int n;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            pt_ch.valid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge i_clk);
        end
        p.point_x = x[COORD_W-1:0];
        p.point_y = y[COORD_W-1:0];
        p.last_point = last;
        pt_ch.valid <= 1'b1;
        pt_ch.data <= p;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
    endtask

    function automatic longint rand_coord(int span);
        if (span == 0) return longint'($signed($urandom_range(0, 20'hFFFFF) << 12)) >>> 12;
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Sends a set of n random points within a coordinate span (0 for full range).
    task automatic send_set(int n, int span);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(span), rand_coord(span), i == n - 1);
    endtask

    typedef struct {
        longint x;
        longint y;
        bit     last;
        bit     chk;
        longint area;
        int     hp;
        bit     few;
    } t_stim_row;

    // Directed sets: each row is a point; a set ends at a row with last set.
    // The answer is typed in on the last row of a set where it is plain.
    t_stim_row stim_rows [22] = '{
        '{0, 0, 1, 1, 0, 0, 1},                           // single point: too few
        '{5, 5, 0, 0, 0, 0, 0}, '{-3, 7, 1, 1, 0, 0, 1},  // two points: too few
        '{0, 0, 0, 0, 0, 0, 0}, '{4, 0, 0, 0, 0, 0, 0},
        '{0, 3, 1, 1, 12, 3, 0},                          // triangle, doubled area 12
        '{-524288, -524288, 0, 0, 0, 0, 0}, '{524287, -524288, 0, 0, 0, 0, 0},
        '{524287, 524287, 0, 0, 0, 0, 0},
        '{-524288, 524287, 1, 1, 64'd2199019061250, 4, 0}, // full-range square
        '{2, 2, 0, 0, 0, 0, 0}, '{2, 2, 0, 0, 0, 0, 0},
        '{2, 2, 1, 1, 0, 1, 0},                           // all duplicates of pivot
        '{0, 0, 0, 0, 0, 0, 0}, '{1, 1, 0, 0, 0, 0, 0},
        '{2, 2, 0, 0, 0, 0, 0}, '{3, 3, 1, 0, 0, 0, 0},   // collinear
        '{0, 0, 0, 0, 0, 0, 0}, '{4, 0, 0, 0, 0, 0, 0},
        '{4, 4, 0, 0, 0, 0, 0}, '{0, 4, 0, 0, 0, 0, 0},
        '{2, 2, 1, 1, 32, 4, 0}                           // interior point
    };

    initial begin
        t_result tv;
        pt_ch.valid = 1'b0;
        pt_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            tv = '0;
            tv.doubled_area = stim_rows[i].area[AREA_W-1:0];
            tv.hull_points = HULL_W'(stim_rows[i].hp);
            tv.too_few = stim_rows[i].few;
            typed_chk <= stim_rows[i].chk;
            typed_val <= tv;
            send_point(stim_rows[i].x, stim_rows[i].y, stim_rows[i].last);
        end
        typed_chk <= 1'b0;

        // One large set for a long sort.
        send_set(200, 1000);

        // Pressure: hold the receiver off while several sets keep coming.
        long_hold = 1'b1;
        for (int s = 0; s < 6; s++) send_set($urandom_range(3, 8), 50);

        // Random sets, mostly small.
        for (int s = 0; s < 80; s++) begin
            case ($urandom_range(0, 5))
                0: send_set($urandom_range(1, 2), 0);
                1: send_set($urandom_range(3, 10), 0);
                2: send_set($urandom_range(3, 10), 3);  // many collinear and duplicates
                default: send_set($urandom_range(3, 9), 1000);
            endcase
            if (s == 60) quiet_mode = 1'b1;
        end
        pt_ch.valid <= 1'b0;

        while (hull_expect_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && hull_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[sim.f]
sv/chull_pkg.sv
sv/chull_stream_if.sv
sv/chull_mac.sv
sv/convex_hull_area.sv
bench/tb_convex_hull_area.sv
